### design/matrix3x3_inverse_defines.svh
// ----------------------------------------------------------------------------
// matrix3x3_inverse_defines.svh
// Assertion macros shared by the checker of the 3x3 matrix inverse block.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH

// Implication checked on every rising clock edge outside of reset.
`define MI3_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mi3 check failed");

// Condition that must never be seen outside of reset.
`define MI3_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("mi3 forbidden condition");

`endif

### design/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Widths, limits and the queue entry type of the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mi3_pkg;

    localparam int EW = 32;                 // element width
    localparam int FB = 16;                 // fraction bits
    localparam int NE = 9;                  // elements per matrix
    localparam int PW = 2 * EW;             // element product
    localparam int CW = PW + 1;             // cofactor
    localparam int TW = 2 * EW + 1;         // partial product in the determinant
    localparam int DW = 3 * EW + 3;         // determinant
    localparam int CMPW = DW + EW;          // divider remainder and divisor shift
    localparam int QDEPTH = 8;
    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = QAW + 1;
    localparam int FRONT_STAGES = 6;
    localparam int BACK_STAGES = EW + 1;
    localparam int BUSY_LIMIT = QDEPTH - FRONT_STAGES - 1;
    localparam int ITEM_LATENCY = FRONT_STAGES + EW + 3;

    localparam logic [EW-1:0] LIM_NEG = EW'(1) << (EW - 1);
    localparam logic [EW-1:0] LIM_POS = LIM_NEG - EW'(1);

    typedef struct packed {
        logic [NE-1:0][CW-1:0] cmag;        // cofactor magnitudes, already transposed
        logic [NE-1:0]         cneg;
        logic [DW-1:0]         dmag;
        logic                  dneg;
        logic                  singular;
    } job_t;

endpackage

`default_nettype wire

### design/mi3_front.sv
// ----------------------------------------------------------------------------
// mi3_front
// Accepts a matrix, forms cofactors and the determinant, classifies it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mi3_front import mi3_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [NE-1:0][EW-1:0]  a,
    input  wire logic [QCW-1:0]         q_count,
    output logic                        busy,
    output logic                        push,
    output job_t                        job
);

    logic [FRONT_STAGES-1:0] v_reg;
    logic                    busy_reg;
    logic                    accept;

    logic signed [EW-1:0] a_reg    [NE];
    logic signed [PW-1:0] p_reg    [NE];
    logic signed [PW-1:0] q_reg    [NE];
    logic signed [CW-1:0] cof3_reg [NE];
    logic signed [CW-1:0] cof4_reg [NE];
    logic signed [CW-1:0] cof5_reg [NE];
    logic signed [CW-1:0] cof6_reg [NE];
    logic signed [EW-1:0] col2_reg [3];
    logic signed [EW-1:0] col3_reg [3];
    logic signed [TW-1:0] plo_reg  [3];
    logic signed [TW-1:0] phi_reg  [3];
    logic signed [DW-1:0] term_reg [3];
    logic signed [DW-1:0] det_reg;

    logic signed [PW-1:0] p_next    [NE];
    logic signed [PW-1:0] q_next    [NE];
    logic signed [CW-1:0] cof_next  [NE];
    logic signed [TW-1:0] plo_next  [3];
    logic signed [TW-1:0] phi_next  [3];
    logic signed [DW-1:0] term_next [3];
    logic signed [DW-1:0] det_next;

    function automatic int idx(input int r, input int c);
        return (r % 3) * 3 + (c % 3);
    endfunction

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                p_next[r*3+c] = a_reg[idx(r+1, c+1)] * a_reg[idx(r+2, c+2)];
                q_next[r*3+c] = a_reg[idx(r+1, c+2)] * a_reg[idx(r+2, c+1)];
            end
        end
        for (int i = 0; i < NE; i++)
        begin
            cof_next[i] = p_reg[i] - q_reg[i];
        end
    end

    // The determinant term a(r,0) * C(r,0) is split at EW bits of the cofactor.
    always_comb
    begin
        logic signed [DW-1:0] hi_ext;
        logic signed [DW-1:0] lo_ext;
        for (int r = 0; r < 3; r++)
        begin
            plo_next[r] = col3_reg[r] * $signed({1'b0, cof3_reg[r*3][EW-1:0]});
            phi_next[r] = col3_reg[r] * $signed(cof3_reg[r*3][CW-1:EW]);
        end
        for (int r = 0; r < 3; r++)
        begin
            hi_ext       = phi_reg[r];
            lo_ext       = plo_reg[r];
            term_next[r] = (hi_ext <<< EW) + lo_ext;
        end
        det_next = term_reg[0] + term_reg[1] + term_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            busy_reg <= 1'b1;
        end
        else
        begin
            v_reg    <= {v_reg[FRONT_STAGES-2:0], accept};
            busy_reg <= (q_count > QCW'(BUSY_LIMIT));
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < NE; i++)
            begin
                a_reg[i] <= a[i];
            end
        end
        for (int i = 0; i < NE; i++)
        begin
            p_reg[i]    <= p_next[i];
            q_reg[i]    <= q_next[i];
            cof3_reg[i] <= cof_next[i];
            cof4_reg[i] <= cof3_reg[i];
            cof5_reg[i] <= cof4_reg[i];
            cof6_reg[i] <= cof5_reg[i];
        end
        for (int r = 0; r < 3; r++)
        begin
            col2_reg[r] <= a_reg[r*3];
            col3_reg[r] <= col2_reg[r];
            plo_reg[r]  <= plo_next[r];
            phi_reg[r]  <= phi_next[r];
            term_reg[r] <= term_next[r];
        end
        det_reg <= det_next;
    end

    // Inverse element (i,j) divides cofactor (j,i), so the transpose happens here.
    always_comb
    begin
        logic signed [CW-1:0] cv;
        job.dneg     = det_reg[DW-1];
        job.dmag     = job.dneg ? DW'(-det_reg) : DW'(det_reg);
        job.singular = (det_reg == '0);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cv                = cof6_reg[j*3+i];
                job.cneg[i*3+j]   = cv[CW-1];
                job.cmag[i*3+j]   = cv[CW-1] ? CW'(-cv) : CW'(cv);
            end
        end
    end

    assign push = v_reg[FRONT_STAGES-1];

endmodule

`default_nettype wire

### design/mi3_queue.sv
// ----------------------------------------------------------------------------
// mi3_queue
// Short queue of classified matrices between the front and the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mi3_queue import mi3_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire job_t       job_in,
    output logic            head_valid,
    output job_t            head,
    output logic [QCW-1:0]  count
);

    job_t             mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;
    logic             pop;

    // The divider pipeline never stalls, so the head leaves as soon as it shows.
    assign pop        = (count_reg != '0);
    assign head_valid = pop;
    assign head       = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

`default_nettype wire

### design/mi3_back.sv
// ----------------------------------------------------------------------------
// mi3_back
// Pipelined restoring division of the nine cofactors by the determinant,
// then sign, saturation and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mi3_back import mi3_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   head_valid,
    input  wire job_t                   head,
    output logic                        done,
    output logic [NE-1:0][EW-1:0]       r,
    output logic                        singular,
    output logic                        saturated
);

    logic [CMPW-1:0]        rem_reg  [BACK_STAGES][NE];
    logic [EW-1:0]          quo_reg  [BACK_STAGES][NE];
    logic [NE-1:0]          big_reg  [BACK_STAGES];
    logic [NE-1:0]          neg_reg  [BACK_STAGES];
    logic [DW-1:0]          dm_reg   [BACK_STAGES];
    logic                   sing_reg [BACK_STAGES];
    logic [BACK_STAGES-1:0] bv_reg;

    logic [NE-1:0][EW-1:0]  r_reg;
    logic [NE-1:0][EW-1:0]  r_next;
    logic                   done_reg;
    logic                   singular_reg;
    logic                   saturated_reg;
    logic                   sat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            bv_reg   <= {bv_reg[BACK_STAGES-2:0], head_valid};
            done_reg <= bv_reg[BACK_STAGES-1];
        end
    end

    for (genvar s = 0; s < BACK_STAGES; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            // A quotient of 2^EW or more is out of range for any sign.
            always_ff @(posedge clk)
            begin
                logic [CMPW-1:0] num;
                logic [CMPW-1:0] dsh;
                dsh = CMPW'(head.dmag) << EW;
                for (int e = 0; e < NE; e++)
                begin
                    num           = CMPW'(head.cmag[e]) << (2 * FB);
                    rem_reg[0][e] <= num;
                    quo_reg[0][e] <= '0;
                    big_reg[0][e] <= (num >= dsh);
                end
                neg_reg[0]  <= head.cneg ^ {NE{head.dneg}};
                dm_reg[0]   <= head.dmag;
                sing_reg[0] <= head.singular;
            end
        end
        else
        begin : g_bit
            always_ff @(posedge clk)
            begin
                logic [CMPW-1:0] dsh;
                logic            ge;
                dsh = CMPW'(dm_reg[s-1]) << (EW - s);
                for (int e = 0; e < NE; e++)
                begin
                    ge = (rem_reg[s-1][e] >= dsh);
                    rem_reg[s][e] <= ge ? rem_reg[s-1][e] - dsh : rem_reg[s-1][e];
                    quo_reg[s][e] <= quo_reg[s-1][e] | (ge ? (EW'(1) << (EW - s)) : '0);
                end
                big_reg[s]  <= big_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                dm_reg[s]   <= dm_reg[s-1];
                sing_reg[s] <= sing_reg[s-1];
            end
        end
    end

    always_comb
    begin
        logic [EW-1:0] mag;
        logic          big;
        sat_next = 1'b0;
        for (int e = 0; e < NE; e++)
        begin
            mag = quo_reg[BACK_STAGES-1][e];
            big = big_reg[BACK_STAGES-1][e];
            if (sing_reg[BACK_STAGES-1])
            begin
                r_next[e] = '0;
            end
            else if (neg_reg[BACK_STAGES-1][e])
            begin
                if (big || mag > LIM_NEG)
                begin
                    r_next[e] = LIM_NEG;
                    sat_next  = 1'b1;
                end
                else
                begin
                    r_next[e] = -mag;
                end
            end
            else
            begin
                if (big || mag > LIM_POS)
                begin
                    r_next[e] = LIM_POS;
                    sat_next  = 1'b1;
                end
                else
                begin
                    r_next[e] = mag;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg         <= r_next;
        singular_reg  <= sing_reg[BACK_STAGES-1];
        saturated_reg <= sat_next && !sing_reg[BACK_STAGES-1];
    end

    assign done      = done_reg;
    assign r         = r_reg;
    assign singular  = singular_reg;
    assign saturated = saturated_reg;

endmodule

`default_nettype wire

### design/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Inverse of a 3x3 signed Q16.16 matrix by the adjugate, saturated.
// ----------------------------------------------------------------------------
// A matrix is taken when start is high and busy is low, one matrix per clock.
// Its result shows for exactly one cycle with done high, after the 6 front
// stages for cofactors and determinant, the queue, the 33 stages of the
// pipelined divider and one output register; the receiver cannot stall.
// Busy is high only in the first cycle after reset. A zero determinant
// gives all-zero elements with singular set.
`timescale 1ns / 1ps
`default_nettype none

module matrix3x3_inverse import mi3_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [EW-1:0] a00,
    input  wire logic [EW-1:0] a01,
    input  wire logic [EW-1:0] a02,
    input  wire logic [EW-1:0] a10,
    input  wire logic [EW-1:0] a11,
    input  wire logic [EW-1:0] a12,
    input  wire logic [EW-1:0] a20,
    input  wire logic [EW-1:0] a21,
    input  wire logic [EW-1:0] a22,
    output logic               done,
    output logic [EW-1:0]      r00,
    output logic [EW-1:0]      r01,
    output logic [EW-1:0]      r02,
    output logic [EW-1:0]      r10,
    output logic [EW-1:0]      r11,
    output logic [EW-1:0]      r12,
    output logic [EW-1:0]      r20,
    output logic [EW-1:0]      r21,
    output logic [EW-1:0]      r22,
    output logic               singular,
    output logic               saturated
);

    logic [NE-1:0][EW-1:0] a_vec;
    logic [NE-1:0][EW-1:0] r_vec;
    logic [QCW-1:0]        q_count;
    logic                  push;
    logic                  head_valid;
    job_t                  job;
    job_t                  head;

    assign a_vec = {a22, a21, a20, a12, a11, a10, a02, a01, a00};

    mi3_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .a       (a_vec),
        .q_count (q_count),
        .busy    (busy),
        .push    (push),
        .job     (job)
    );

    mi3_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .job_in     (job),
        .head_valid (head_valid),
        .head       (head),
        .count      (q_count)
    );

    mi3_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .done       (done),
        .r          (r_vec),
        .singular   (singular),
        .saturated  (saturated)
    );

    assign r00 = r_vec[0];
    assign r01 = r_vec[1];
    assign r02 = r_vec[2];
    assign r10 = r_vec[3];
    assign r11 = r_vec[4];
    assign r12 = r_vec[5];
    assign r20 = r_vec[6];
    assign r21 = r_vec[7];
    assign r22 = r_vec[8];

endmodule

`default_nettype wire

### design/mi3_checker.sv
// ----------------------------------------------------------------------------
// mi3_checker
// Port-level checks of the 3x3 matrix inverse, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "matrix3x3_inverse_defines.svh"

module mi3_checker import mi3_pkg::*;
(
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          done,
    input wire logic [EW-1:0] r00,
    input wire logic [EW-1:0] r01,
    input wire logic [EW-1:0] r02,
    input wire logic [EW-1:0] r10,
    input wire logic [EW-1:0] r11,
    input wire logic [EW-1:0] r12,
    input wire logic [EW-1:0] r20,
    input wire logic [EW-1:0] r21,
    input wire logic [EW-1:0] r22,
    input wire logic          singular,
    input wire logic          saturated
);

    logic all_zero;

    assign all_zero = (r00 == '0) && (r01 == '0) && (r02 == '0) && (r10 == '0)
                   && (r11 == '0) && (r12 == '0) && (r20 == '0) && (r21 == '0)
                   && (r22 == '0);

    // Every transaction gives its result after the fixed latency.
    `MI3_ASSERT(a_latency_fwd, (start && !busy) |-> ##ITEM_LATENCY done)
    // No result appears without a transaction that fixed latency ago.
    `MI3_ASSERT(a_latency_back, done |-> $past(start && !busy, ITEM_LATENCY))
    // A singular matrix reads as all zeros and is never marked as clipped.
    `MI3_NEVER(a_singular_clean, done && singular && (saturated || !all_zero))

endmodule

bind matrix3x3_inverse mi3_checker u_mi3_checker (.*);

`default_nettype wire
